// File: src/sbdasc_pkg.sv
// shared constants and types for the signed binary to decimal ascii converter
package sbdasc_pkg;

   // width of the signed input value
   localparam int VALUE_BITS    = 32;
   // input bus padded to whole bytes
   localparam int REQ_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
   // magnitude rounded up to an even width, two bits enter per step
   localparam int MAG_BITS      = VALUE_BITS + (VALUE_BITS % 2);
   localparam int CONV_STEPS    = MAG_BITS / 2;
   localparam int STEP_BITS     = $clog2(CONV_STEPS + 1);
   // decimal digits of the largest magnitude, 2**(VALUE_BITS-1)
   localparam int BCD_DIGITS    = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int BCD_BITS      = 4 * BCD_DIGITS;
   localparam int DIGIT_CNT_BITS = $clog2(BCD_DIGITS + 1);

   // output character
   localparam int CHAR_BITS     = 6;
   localparam int RSP_DATA_BITS = 8;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;
   localparam logic [3:0] BCD_ADJUST_MIN = 4'd5;
   localparam logic [3:0] BCD_ADJUST_ADD = 4'd3;

   // converter status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } sbdasc_conv_status_type;

endpackage

// File: src/sbdasc_dabble.sv
// binary to bcd converter, shift-and-add-3, two bits per cycle
module sbdasc_dabble (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sbdasc_pkg::MAG_BITS-1:0] magnitude,
   output sbdasc_pkg::sbdasc_conv_status_type status,
   output logic [sbdasc_pkg::BCD_BITS-1:0] bcd
);
   import sbdasc_pkg::*;

   logic [MAG_BITS-1:0]  mag_ff, mag_in;
   logic [BCD_BITS-1:0]  bcd_ff, bcd_in;
   logic [STEP_BITS-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BCD_BITS-1:0]  stage_a, stage_b;
   logic [BCD_BITS-1:0]  adj_a, adj_b;

   // two dependent adjust-and-shift steps on the bcd word
   always_comb begin
      adj_a = bcd_ff;
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= BCD_ADJUST_MIN) begin
            adj_a[4*d +: 4] = bcd_ff[4*d +: 4] + BCD_ADJUST_ADD;
         end
      end
      stage_a = {adj_a[BCD_BITS-2:0], mag_ff[MAG_BITS-1]};
      adj_b = stage_a;
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (stage_a[4*d +: 4] >= BCD_ADJUST_MIN) begin
            adj_b[4*d +: 4] = stage_a[4*d +: 4] + BCD_ADJUST_ADD;
         end
      end
      stage_b = {adj_b[BCD_BITS-2:0], mag_ff[MAG_BITS-2]};
   end

   // step sequencing
   always_comb begin
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         mag_in   = magnitude;
         bcd_in   = '0;
         count_in = STEP_BITS'(CONV_STEPS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         mag_in   = {mag_ff[MAG_BITS-3:0], 2'b00};
         bcd_in   = stage_b;
         count_in = count_ff - 1'b1;
         if (count_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

endmodule

// File: src/signed_binary_to_decimal_ascii_top.sv
// top level: signed integer in, decimal ascii characters out
//
// One transaction on the req_ channel carries a signed two's complement
// value. The block answers with its decimal text on the rsp_ channel, one
// character per transaction, most significant first: a minus sign for a
// negative value, then the digits without leading zeros ("0" for zero).
// rsp_tlast marks the final character, so a value gives 1 to 11 characters.
// The most negative value is handled and gives "-2147483648".
// Timing: the value is converted by a shift-and-add-3 loop that takes two
// magnitude bits per cycle and is then handed to the sequencer. The ten digit
// positions are then walked at one per cycle, the sending of a digit waiting
// on a stall: leading zeros are dropped, then each digit is sent; a negative
// value sends its minus sign first. The next value is taken the cycle after
// the last character enters the output register. A stall on rsp_tready
// holds the output register and stops the sequencer at its next character;
// nothing is lost. Reset clears the sequencer and the output valid; no
// partial output survives it.
module signed_binary_to_decimal_ascii_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] value
   input  logic [sbdasc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [5:0] character, [7:6] zero
   output logic [sbdasc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                                rsp_tlast
);
   import sbdasc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CONV  = 3'd1;
   localparam logic [2:0] S_SIGN  = 3'd2;
   localparam logic [2:0] S_SKIP  = 3'd3;
   localparam logic [2:0] S_DIGIT = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic                      neg_ff, neg_in;
   logic [BCD_BITS-1:0]       digits_ff, digits_in;
   logic [DIGIT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                      out_valid_ff, out_valid_in;
   logic [CHAR_BITS-1:0]      out_char_ff, out_char_in;
   logic                      out_last_ff, out_last_in;

   logic                      accept;
   logic                      out_free;
   logic [VALUE_BITS-1:0]     raw;
   logic [VALUE_BITS-1:0]     mag;
   logic [3:0]                top_digit;
   sbdasc_conv_status_type    conv_status;
   logic [BCD_BITS-1:0]       conv_bcd;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   // magnitude of the incoming value, unsigned so the most negative fits
   assign raw = req_tdata[VALUE_BITS-1:0];
   assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

   sbdasc_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .magnitude (MAG_BITS'(mag)),
      .status    (conv_status),
      .bcd       (conv_bcd)
   );

   assign top_digit = digits_ff[BCD_BITS-1 -: 4];

   // character sequencer
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      digits_in    = digits_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               neg_in   = raw[VALUE_BITS-1];
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (conv_status.done) begin
               digits_in = conv_bcd;
               cnt_in    = DIGIT_CNT_BITS'(BCD_DIGITS);
               state_in  = neg_ff ? S_SIGN : S_SKIP;
            end
         end
         S_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ASCII_MINUS;
               out_last_in  = 1'b0;
               state_in     = S_SKIP;
            end
         end
         S_SKIP: begin
            // drop leading zeros, keeping at least one digit
            if (top_digit == 4'd0 && cnt_ff > DIGIT_CNT_BITS'(1)) begin
               digits_in = {digits_ff[BCD_BITS-5:0], 4'd0};
               cnt_in    = cnt_ff - 1'b1;
            end else begin
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ASCII_ZERO + {2'b00, top_digit};
               out_last_in  = (cnt_ff == DIGIT_CNT_BITS'(1));
               if (cnt_ff == DIGIT_CNT_BITS'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  digits_in = {digits_ff[BCD_BITS-5:0], 4'd0};
                  cnt_in    = cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      neg_ff      <= neg_in;
      digits_ff   <= digits_in;
      cnt_ff      <= cnt_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(out_char_ff);
   assign rsp_tlast  = out_last_ff;

endmodule
